// File: hdl/fpc_pkg.sv
// Shared types and constants for the fractional-N PLL register calculator.
// Used by fpc_word_out and by the top level; depends on nothing else.
package fpc_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_REF_FREQ  = 3'd0;
   localparam logic [2:0] CSR_REF_DIV   = 3'd1;
   localparam logic [2:0] CSR_DOUBLER   = 3'd2;
   localparam logic [2:0] CSR_HALVER    = 3'd3;
   localparam logic [2:0] CSR_BAND_FAST = 3'd4;
   localparam logic [2:0] CSR_FB_VCO    = 3'd5;
   localparam logic [2:0] CSR_PUMP      = 3'd6;
   localparam logic [2:0] CSR_RF_POWER  = 3'd7;

   // Word slots, in the order they leave the block.
   localparam logic [2:0] WORD_R5 = 3'd0;
   localparam logic [2:0] WORD_R4 = 3'd1;
   localparam logic [2:0] WORD_R3 = 3'd2;
   localparam logic [2:0] WORD_R2 = 3'd3;
   localparam logic [2:0] WORD_R1 = 3'd4;
   localparam logic [2:0] WORD_R0 = 3'd5;

   localparam logic [39:0] VCO_MIN_HZ   = 40'd2200000000;
   localparam logic [39:0] VCO_MAX_HZ   = 40'd4400000000;
   localparam logic [26:0] PFD_INT_MAX  = 27'd90000000;
   localparam logic [9:0]  MOD_STEP_HZ  = 10'd1000;
   localparam logic [18:0] BAND_FAST_HZ = 19'd500000;
   localparam logic [18:0] BAND_SLOW_HZ = 19'd125000;
   localparam logic [7:0]  BAND_FAST_MAX = 8'd254;
   localparam logic [7:0]  BAND_SLOW_MAX = 8'd255;
   localparam logic [11:0] MOD_MIN = 12'd2;
   localparam logic [11:0] MOD_MAX = 12'd4095;
   localparam logic [11:0] CLK_DIV_VALUE = 12'd150;

   typedef struct packed {
      logic [2:0]  div;
      logic [7:0]  band;
      logic [11:0] modv;
      logic [15:0] intv;
      logic [11:0] fracv;
      logic        int_mode;
      logic        range_err;
      logic        clamped;
      logic        too_high;
   } fpc_item_type;

   typedef struct packed {
      logic       fb_vco;
      logic [1:0] rf_power;
      logic       band_fast;
      logic       doubler;
      logic       halver;
      logic [9:0] rdiv;
      logic [3:0] pump;
   } fpc_cfg_type;

endpackage

// File: hdl/fpc_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a side-band payload alongside; needs no package.
module fpc_div_pipe #(
   parameter int N_W  = 8,
   parameter int D_W  = 8,
   parameter int Q_W  = 8,
   parameter int SB_W = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            enable,
   input  logic            in_valid,
   input  logic [N_W-1:0]  in_num,
   input  logic [D_W-1:0]  in_den,
   input  logic [SB_W-1:0] in_sb,
   output logic            out_valid,
   output logic [Q_W-1:0]  out_quo,
   output logic [D_W-1:0]  out_rem,
   output logic [SB_W-1:0] out_sb
);

   localparam int A_W = D_W + Q_W;

   // The accumulator holds the partial remainder above the unused dividend bits,
   // which are replaced by quotient bits from the bottom as the stages go by.
   logic            valid_w [Q_W+1];
   logic [A_W-1:0]  acc_w   [Q_W+1];
   logic [D_W-1:0]  den_w   [Q_W+1];
   logic [SB_W-1:0] sb_w    [Q_W+1];

   assign valid_w[0] = in_valid;
   assign acc_w[0]   = A_W'(in_num);
   assign den_w[0]   = in_den;
   assign sb_w[0]    = in_sb;

   for (genvar i = 0; i < Q_W; i++) begin : g_stage
      logic            valid_ff;
      logic [A_W-1:0]  acc_ff;
      logic [A_W-1:0]  acc_in;
      logic [D_W-1:0]  den_ff;
      logic [SB_W-1:0] sb_ff;
      logic [A_W:0]    shifted;
      logic [D_W:0]    upper;
      logic [D_W:0]    diff;

      always_comb begin
         shifted = {acc_w[i], 1'b0};
         upper   = shifted[A_W:Q_W];
         diff    = upper - {1'b0, den_w[i]};
         if (upper >= {1'b0, den_w[i]}) begin
            acc_in = {diff[D_W-1:0], shifted[Q_W-1:1], 1'b1};
         end else begin
            acc_in = {upper[D_W-1:0], shifted[Q_W-1:1], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (enable) begin
            valid_ff <= valid_w[i];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            acc_ff <= acc_in;
            den_ff <= den_w[i];
            sb_ff  <= sb_w[i];
         end
      end

      assign valid_w[i+1] = valid_ff;
      assign acc_w[i+1]   = acc_ff;
      assign den_w[i+1]   = den_ff;
      assign sb_w[i+1]    = sb_ff;
   end

   assign out_valid = valid_w[Q_W];
   assign out_quo   = acc_w[Q_W][Q_W-1:0];
   assign out_rem   = acc_w[Q_W][A_W-1:Q_W];
   assign out_sb    = sb_w[Q_W];

endmodule

// File: hdl/fpc_word_out.sv
// Output stage: holds one finished result and sends its six register words.
// Depends on fpc_pkg for the item and configuration structs.
module fpc_word_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_valid,
   output logic                 load_ready,
   input  fpc_pkg::fpc_item_type load_item,
   input  fpc_pkg::fpc_cfg_type  cfg,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_reg_word,
   output logic                 rsp_last_word,
   output logic                 rsp_range_error,
   output logic                 rsp_value_clamped,
   output logic                 rsp_pfd_too_high
);

   logic                  busy_ff;
   logic                  busy_in;
   logic [2:0]            slot_ff;
   logic [2:0]            slot_in;
   fpc_pkg::fpc_item_type item_ff;
   logic                  load_take;
   logic                  im;

   // A new result may be loaded in the cycle in which R0 is handed over.
   assign load_ready = !busy_ff || (rsp_ready && slot_ff == fpc_pkg::WORD_R0);
   assign load_take  = load_valid && load_ready;

   always_comb begin
      busy_in = busy_ff;
      slot_in = slot_ff;
      if (load_take) begin
         busy_in = 1'b1;
         slot_in = fpc_pkg::WORD_R5;
      end else if (busy_ff && rsp_ready) begin
         if (slot_ff == fpc_pkg::WORD_R0) begin
            busy_in = 1'b0;
         end else begin
            slot_in = slot_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         slot_ff <= fpc_pkg::WORD_R5;
      end else begin
         busy_ff <= busy_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_take) begin
         item_ff <= load_item;
      end
   end

   assign im = item_ff.int_mode;

   always_comb begin
      case (slot_ff)
         fpc_pkg::WORD_R5: rsp_reg_word = {9'd0, 1'b1, 1'b0, 2'b11, 16'd0, 3'd5};
         fpc_pkg::WORD_R4: rsp_reg_word = {8'd0, cfg.fb_vco, item_ff.div, item_ff.band,
                                           1'b0, 1'b1, 4'd0, 1'b1, cfg.rf_power, 3'd4};
         fpc_pkg::WORD_R3: rsp_reg_word = {8'd0, cfg.band_fast, im, im, 6'd0,
                                           fpc_pkg::CLK_DIV_VALUE, 3'd3};
         fpc_pkg::WORD_R2: rsp_reg_word = {6'd0, cfg.doubler, cfg.halver, cfg.rdiv, 1'b0,
                                           cfg.pump, im, im, 4'd0, 3'd2};
         fpc_pkg::WORD_R1: rsp_reg_word = {4'd0, 1'b1, 11'd0, 1'b1, item_ff.modv, 3'd1};
         fpc_pkg::WORD_R0: rsp_reg_word = {1'b0, item_ff.intv, item_ff.fracv, 3'd0};
         default:          rsp_reg_word = 32'd0;
      endcase
   end

   assign rsp_valid         = busy_ff;
   assign rsp_last_word     = (slot_ff == fpc_pkg::WORD_R0);
   assign rsp_range_error   = item_ff.range_err;
   assign rsp_value_clamped = item_ff.clamped;
   assign rsp_pfd_too_high  = item_ff.too_high;

endmodule

// File: hdl/fracn_pll_register_calculator.sv
// Top level of the fractional-N PLL register calculator.
// Depends on fpc_pkg, fpc_div_pipe and fpc_word_out.
//
//   channel  ports                        direction  meaning
//   req      req_valid/ready, target      in         requested output frequency
//   rsp      rsp_valid/ready, word+flags  out        six register words, R5 to R0
//   csr      csr_valid/ready, index/data  in         configuration write
//
// A transaction on req produces six rsp words, handed over back to back while rsp_ready
// stays high; when the pipeline is full, a request is taken only as an R0 word goes out.
// The delay from an accepted request to the offer of R5 comes mostly from the
// 51-stage integer divider and the 12-stage fraction divider. Reset is synchronous; it
// empties the pipeline and restores the configuration defaults. A stall on rsp freezes
// the request pipeline in place once a finished result waits at its end.
module fracn_pll_register_calculator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [32:0] req_target_freq_hz,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_reg_word,
   output logic        rsp_last_word,
   output logic        rsp_range_error,
   output logic        rsp_value_clamped,
   output logic        rsp_pfd_too_high,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [27:0] csr_data
);

   // Configuration registers.
   logic [27:0] ref_freq_ff;
   logic [9:0]  ref_div_ff;
   logic        doubler_ff;
   logic        halver_ff;
   logic        band_fast_ff;
   logic        fb_vco_ff;
   logic [3:0]  pump_ff;
   logic [1:0]  rf_power_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_freq_ff  <= 28'd25000000;
         ref_div_ff   <= 10'd1;
         doubler_ff   <= 1'b0;
         halver_ff    <= 1'b0;
         band_fast_ff <= 1'b0;
         fb_vco_ff    <= 1'b1;
         pump_ff      <= 4'd7;
         rf_power_ff  <= 2'd3;
      end else if (csr_valid) begin
         case (csr_index)
            fpc_pkg::CSR_REF_FREQ:  ref_freq_ff  <= csr_data;
            fpc_pkg::CSR_REF_DIV:   ref_div_ff   <= csr_data[9:0];
            fpc_pkg::CSR_DOUBLER:   doubler_ff   <= csr_data[0];
            fpc_pkg::CSR_HALVER:    halver_ff    <= csr_data[0];
            fpc_pkg::CSR_BAND_FAST: band_fast_ff <= csr_data[0];
            fpc_pkg::CSR_FB_VCO:    fb_vco_ff    <= csr_data[0];
            fpc_pkg::CSR_PUMP:      pump_ff      <= csr_data[3:0];
            fpc_pkg::CSR_RF_POWER:  rf_power_ff  <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // PFD is num/den; an R counter of zero counts as one.
   logic [9:0]  rdiv_eff;
   logic [28:0] num;
   logic [10:0] den;
   logic        num_zero;

   assign rdiv_eff = (ref_div_ff == 10'd0) ? 10'd1 : ref_div_ff;
   assign num      = doubler_ff ? {ref_freq_ff, 1'b0} : {1'b0, ref_freq_ff};
   assign den      = halver_ff ? {rdiv_eff, 1'b0} : {1'b0, rdiv_eff};
   assign num_zero = (ref_freq_ff == 28'd0);

   // Values that depend on configuration only. These dividers run freely; their
   // results have settled long before a request reaches the stage that reads them.
   logic [20:0] den_mod_ff;
   logic [29:0] den_band_ff;
   logic        too_high_ff;
   logic [19:0] mod_quo;
   logic [12:0] band_quo;
   logic [11:0] modv_ff;
   logic        mod_clamp_ff;
   logic [7:0]  band_ff;
   logic        band_clamp_ff;
   logic [7:0]  band_max;

   always_ff @(posedge clock) begin
      den_mod_ff  <= 21'(den) * 21'(fpc_pkg::MOD_STEP_HZ);
      den_band_ff <= 30'(den) * 30'(band_fast_ff ? fpc_pkg::BAND_FAST_HZ
                                                 : fpc_pkg::BAND_SLOW_HZ);
      too_high_ff <= 38'(num) > (38'(den) * 38'(fpc_pkg::PFD_INT_MAX));
   end

   fpc_div_pipe #(.N_W(29), .D_W(21), .Q_W(20), .SB_W(1)) u_mod_div (
      .clock    (clock),
      .reset    (reset),
      .enable   (1'b1),
      .in_valid (1'b1),
      .in_num   (num),
      .in_den   (den_mod_ff),
      .in_sb    (1'b0),
      .out_valid(),
      .out_quo  (mod_quo),
      .out_rem  (),
      .out_sb   ()
   );

   fpc_div_pipe #(.N_W(29), .D_W(30), .Q_W(13), .SB_W(1)) u_band_div (
      .clock    (clock),
      .reset    (reset),
      .enable   (1'b1),
      .in_valid (1'b1),
      .in_num   (num),
      .in_den   (den_band_ff),
      .in_sb    (1'b0),
      .out_valid(),
      .out_quo  (band_quo),
      .out_rem  (),
      .out_sb   ()
   );

   assign band_max = band_fast_ff ? fpc_pkg::BAND_FAST_MAX : fpc_pkg::BAND_SLOW_MAX;

   always_ff @(posedge clock) begin
      if (mod_quo < 20'(fpc_pkg::MOD_MIN)) begin
         modv_ff      <= fpc_pkg::MOD_MIN;
         mod_clamp_ff <= 1'b1;
      end else if (mod_quo > 20'(fpc_pkg::MOD_MAX)) begin
         modv_ff      <= fpc_pkg::MOD_MAX;
         mod_clamp_ff <= 1'b1;
      end else begin
         modv_ff      <= mod_quo[11:0];
         mod_clamp_ff <= 1'b0;
      end
      if (band_quo > 13'(band_max)) begin
         band_ff       <= band_max;
         band_clamp_ff <= 1'b1;
      end else begin
         band_ff       <= band_quo[7:0];
         band_clamp_ff <= 1'b0;
      end
   end

   // Request pipeline; every stage moves together.
   logic        advance;
   logic        load_ready;

   logic        s0_valid_ff;
   logic [32:0] s0_target_ff;
   logic        s1_valid_ff;
   logic [39:0] s1_fb_ff;
   logic [2:0]  s1_div_ff;
   logic        s1_range_ff;
   logic        s2_valid_ff;
   logic [50:0] s2_scaled_ff;
   logic [3:0]  s2_sb_ff;

   logic [39:0] vco_try [8];
   logic [2:0]  div_in;
   logic        range_in;
   logic [39:0] vco_in;

   always_comb begin
      div_in   = 3'd7;
      range_in = 1'b1;
      for (int d = 0; d < 8; d++) begin
         vco_try[d] = {7'd0, s0_target_ff} << d;
      end
      // Lowest divider in range wins, so scan from the top down.
      for (int d = 7; d >= 0; d--) begin
         if (vco_try[d] >= fpc_pkg::VCO_MIN_HZ && vco_try[d] <= fpc_pkg::VCO_MAX_HZ) begin
            div_in   = 3'(d);
            range_in = 1'b0;
         end
      end
      vco_in = vco_try[div_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_target_ff <= req_target_freq_hz;
         s1_fb_ff     <= fb_vco_ff ? vco_in : {7'd0, s0_target_ff};
         s1_div_ff    <= div_in;
         s1_range_ff  <= range_in;
         s2_scaled_ff <= 51'(s1_fb_ff) * 51'(den);
         s2_sb_ff     <= {s1_div_ff, s1_range_ff};
      end
   end

   // N = scaled / num: integer part and remainder.
   logic        iq_valid;
   logic [50:0] iq_quo;
   logic [28:0] iq_rem;
   logic [3:0]  iq_sb;

   fpc_div_pipe #(.N_W(51), .D_W(29), .Q_W(51), .SB_W(4)) u_int_div (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .in_valid (s2_valid_ff),
      .in_num   (s2_scaled_ff),
      .in_den   (num),
      .in_sb    (s2_sb_ff),
      .out_valid(iq_valid),
      .out_quo  (iq_quo),
      .out_rem  (iq_rem),
      .out_sb   (iq_sb)
   );

   logic        p_valid_ff;
   logic [40:0] p_prod_ff;
   logic [20:0] p_sb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (advance) begin
         p_valid_ff <= iq_valid;
      end
   end

   // Side band: INT low bits, INT overflow, divider, range flag.
   always_ff @(posedge clock) begin
      if (advance) begin
         p_prod_ff <= 41'(modv_ff) * 41'(iq_rem);
         p_sb_ff   <= {iq_quo[15:0], |iq_quo[50:16], iq_sb};
      end
   end

   logic        fq_valid;
   logic [11:0] fq_quo;
   logic [20:0] fq_sb;

   fpc_div_pipe #(.N_W(41), .D_W(29), .Q_W(12), .SB_W(21)) u_frac_div (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .in_valid (p_valid_ff),
      .in_num   (p_prod_ff),
      .in_den   (num),
      .in_sb    (p_sb_ff),
      .out_valid(fq_valid),
      .out_quo  (fq_quo),
      .out_rem  (),
      .out_sb   (fq_sb)
   );

   fpc_pkg::fpc_item_type item;
   fpc_pkg::fpc_cfg_type  cfg;
   logic                  int_over;

   assign int_over = fq_sb[4];

   always_comb begin
      item.div       = fq_sb[3:1];
      item.range_err = fq_sb[0];
      item.band      = band_ff;
      item.modv      = modv_ff;
      if (num_zero) begin
         item.intv  = 16'hFFFF;
         item.fracv = 12'd0;
      end else begin
         item.intv  = int_over ? 16'hFFFF : fq_sb[20:5];
         item.fracv = fq_quo;
      end
      item.int_mode = (item.fracv == 12'd0);
      item.clamped  = band_clamp_ff || mod_clamp_ff || int_over || num_zero;
      item.too_high = item.int_mode && too_high_ff;
   end

   assign cfg.fb_vco    = fb_vco_ff;
   assign cfg.rf_power  = rf_power_ff;
   assign cfg.band_fast = band_fast_ff;
   assign cfg.doubler   = doubler_ff;
   assign cfg.halver    = halver_ff;
   assign cfg.rdiv      = rdiv_eff;
   assign cfg.pump      = pump_ff;

   assign advance   = !fq_valid || load_ready;
   assign req_ready = advance;

   fpc_word_out u_word_out (
      .clock            (clock),
      .reset            (reset),
      .load_valid       (fq_valid),
      .load_ready       (load_ready),
      .load_item        (item),
      .cfg              (cfg),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_reg_word     (rsp_reg_word),
      .rsp_last_word    (rsp_last_word),
      .rsp_range_error  (rsp_range_error),
      .rsp_value_clamped(rsp_value_clamped),
      .rsp_pfd_too_high (rsp_pfd_too_high)
   );

endmodule

// File: verif/fracn_pll_register_calculator_checker.sv
// Checker for the fractional-N PLL register calculator: watches all three channels,
// predicts the six register words of every request and compares them in order.
// Depends on fpc_pkg for the configuration register indexes.
module fracn_pll_register_calculator_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [32:0] req_target_freq_hz,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_reg_word,
   input  logic        rsp_last_word,
   input  logic        rsp_range_error,
   input  logic        rsp_value_clamped,
   input  logic        rsp_pfd_too_high,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [27:0] csr_data,
   output int          fail_count,
   output int          words_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] word;
      logic        last;
      logic        range_err;
      logic        clamped;
      logic        too_high;
   } reg_word_type;

   reg_word_type expected_words[$];

   logic [27:0] ref_hz;
   logic [9:0]  ref_div;
   logic        doubler, halver, band_fast, fb_vco;
   logic [3:0]  pump;
   logic [1:0]  rf_power;

   assign words_pending = expected_words.size();

   function automatic void predict_words(logic [32:0] target);
      logic [63:0] rdiv, num, den, band, div, vco, fb, intv, modv, fracv, scaled, rem;
      logic [63:0] words[6];
      logic        clamped, range_err, too_high, int_mode;
      reg_word_type item;
      rdiv = (ref_div != 0) ? 64'(ref_div) : 64'd1;
      num = 64'(ref_hz) * (64'd1 + doubler);
      den = rdiv * (64'd1 + halver);
      clamped = 1'b0;
      range_err = 1'b1;
      too_high = 1'b0;
      div = 7;
      vco = 0;
      if (band_fast) begin
         band = num / (den * 500000);
         if (band > 254) begin
            band = 254;
            clamped = 1'b1;
         end
      end else begin
         band = num / (den * 125000);
         if (band > 255) begin
            band = 255;
            clamped = 1'b1;
         end
      end
      // The first power-of-two divider that lands the VCO in band wins.
      for (int d = 0; d < 8; d++) begin
         if (range_err) begin
            vco = 64'(target) << d;
            if (vco >= 64'd2200000000 && vco <= 64'd4400000000) begin
               div = d;
               range_err = 1'b0;
            end
         end
      end
      if (range_err) vco = 64'(target) << 7;
      fb = fb_vco ? vco : 64'(target);
      modv = num / (den * 1000);
      if (modv < 2) begin
         modv = 2;
         clamped = 1'b1;
      end
      if (modv > 4095) begin
         modv = 4095;
         clamped = 1'b1;
      end
      if (num == 0) begin
         intv = 65535;
         clamped = 1'b1;
         fracv = 0;
      end else begin
         scaled = fb * den;
         rem = scaled % num;
         intv = scaled / num;
         if (intv > 65535) begin
            intv = 65535;
            clamped = 1'b1;
         end
         fracv = (modv * rem) / num;
      end
      int_mode = (fracv == 0);
      if (int_mode && num > 64'd90000000 * den) too_high = 1'b1;
      words[0] = (64'd1 << 22) | (64'd3 << 19) | 64'd5;
      words[1] = (64'(fb_vco) << 23) | (div << 20) | (band << 12) | (64'd1 << 10)
               | (64'd1 << 5) | (64'(rf_power) << 3) | 64'd4;
      words[2] = (64'(band_fast) << 23) | (64'(int_mode) << 22) | (64'(int_mode) << 21)
               | (64'd150 << 3) | 64'd3;
      words[3] = (64'(doubler) << 25) | (64'(halver) << 24) | ((rdiv & 64'h3FF) << 14)
               | (64'(pump) << 9) | (64'(int_mode) << 8) | (64'(int_mode) << 7) | 64'd2;
      words[4] = (64'd1 << 27) | (64'd1 << 15) | ((modv & 64'hFFF) << 3) | 64'd1;
      words[5] = ((intv & 64'hFFFF) << 15) | ((fracv & 64'hFFF) << 3);
      for (int k = 0; k < 6; k++) begin
         item.word = words[k][31:0];
         item.last = (k == 5);
         item.range_err = range_err;
         item.clamped = clamped;
         item.too_high = too_high;
         expected_words.push_back(item);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         ref_hz <= 28'd25000000;
         ref_div <= 10'd1;
         doubler <= 1'b0;
         halver <= 1'b0;
         band_fast <= 1'b0;
         fb_vco <= 1'b1;
         pump <= 4'd7;
         rf_power <= 2'd3;
         expected_words.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               fpc_pkg::CSR_REF_FREQ:  ref_hz <= csr_data;
               fpc_pkg::CSR_REF_DIV:   ref_div <= csr_data[9:0];
               fpc_pkg::CSR_DOUBLER:   doubler <= csr_data[0];
               fpc_pkg::CSR_HALVER:    halver <= csr_data[0];
               fpc_pkg::CSR_BAND_FAST: band_fast <= csr_data[0];
               fpc_pkg::CSR_FB_VCO:    fb_vco <= csr_data[0];
               fpc_pkg::CSR_PUMP:      pump <= csr_data[3:0];
               fpc_pkg::CSR_RF_POWER:  rf_power <= csr_data[1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_words(req_target_freq_hz);
         if (rsp_valid && rsp_ready) begin
            reg_word_type got, want;
            got = {rsp_reg_word, rsp_last_word, rsp_range_error, rsp_value_clamped,
                   rsp_pfd_too_high};
            if (expected_words.size() == 0) begin
               $display("%t: unexpected word %h", $realtime, rsp_reg_word);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_words.pop_front();
               if (got !== want) begin
                  $display("%t: mismatch expected word %h last %b range %b clamp %b high %b",
                           $realtime, want.word, want.last, want.range_err, want.clamped,
                           want.too_high);
                  $display("%t:          actual   word %h last %b range %b clamp %b high %b",
                           $realtime, got.word, got.last, got.range_err, got.clamped,
                           got.too_high);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// File: verif/fracn_pll_register_calculator_tb.sv
// Top of the register calculator testbench: clock, reset, stimulus and verdict.
// Depends on fpc_pkg, the block itself and fracn_pll_register_calculator_checker.
module fracn_pll_register_calculator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [32:0] req_target_freq_hz = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_reg_word;
   logic        rsp_last_word, rsp_range_error, rsp_value_clamped, rsp_pfd_too_high;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [27:0] csr_data = '0;
   int          fail_count, words_pending;
   int          cycle_count = 0;
   int          gap_pct = 0, stall_pct = 0;
   logic        hold_go = 1'b0;
   int          hold_left = 0;
   logic [27:0] cur_ref = 28'd25000000;

   fracn_pll_register_calculator DUT (.*);
   fracn_pll_register_calculator_checker checker_inst (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // The receiver; a requested long hold-off lets the pipeline fill and stall req.
   always @(posedge clock) begin
      if (hold_go && hold_left == 0) begin
         hold_left <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_left > 1) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (hold_left == 1) hold_left <= -1;
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_target(logic [32:0] t);
      int gaps;
      gaps = 0;
      while ($urandom_range(99) < gap_pct && gaps < 40) gaps++;
      if (gaps > 0) begin
         req_valid <= 1'b0;
         repeat (gaps) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_target_freq_hz <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [27:0] value);
      req_valid <= 1'b0;
      // Only touch configuration with the pipeline drained.
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (70) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == fpc_pkg::CSR_REF_FREQ) cur_ref = value;
   endtask

   task automatic write_all(logic [27:0] rf, logic [9:0] rd, logic dbl, logic hlv,
                            logic fast, logic fbv, logic [3:0] cp, logic [1:0] pw);
      // Upper data bits are junk that the block must mask away.
      write_csr(fpc_pkg::CSR_REF_FREQ, rf);
      write_csr(fpc_pkg::CSR_REF_DIV, {$urandom_range(262143), rd});
      write_csr(fpc_pkg::CSR_DOUBLER, {$urandom_range(134217727), dbl});
      write_csr(fpc_pkg::CSR_HALVER, {$urandom_range(134217727), hlv});
      write_csr(fpc_pkg::CSR_BAND_FAST, {$urandom_range(134217727), fast});
      write_csr(fpc_pkg::CSR_FB_VCO, {$urandom_range(134217727), fbv});
      write_csr(fpc_pkg::CSR_PUMP, {$urandom_range(16777215), cp});
      write_csr(fpc_pkg::CSR_RF_POWER, {$urandom_range(67108863), pw});
   endtask

   function automatic logic [32:0] random_target();
      logic [63:0] t;
      int d;
      d = $urandom_range(6);
      case ($urandom_range(9))
         0, 1, 2, 3, 4: t = (64'd2200000000 + ($urandom % 32'd2200000001)) >> d;
         5: t = {$urandom_range(1), $urandom};
         6: t = $urandom_range(40000000);
         7, 8: t = 64'(cur_ref) * $urandom_range(4400);
         default: t = (($urandom_range(1) ? 64'd2200000000 : 64'd4400000000) >> d)
                      + $urandom_range(2) - 1;
      endcase
      return t[32:0];
   endfunction

   initial begin
      logic [32:0] directed[$];
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 82; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 82; end
            default: begin gap_pct = 23; stall_pct = 23; end
         endcase
         case (ph)
            0: write_all(28'd25000000, 10'd1, 0, 0, 0, 1, 4'd7, 2'd3);
            1: write_all(28'd250000000, 10'd1, 1, 0, 1, 1, 4'd15, 2'd3);
            2: write_all(28'd1000000, 10'd1023, 0, 1, 0, 0, 4'd0, 2'd0);
            3: write_all(28'd0, 10'd0, 1, 1, 1, 0, 4'd9, 2'd1);
            4: write_all(28'hFFFFFFF, 10'd0, 1, 0, 0, 1, 4'd5, 2'd2);
            default: write_all($urandom_range(250000000, 1000000),
                               $urandom_range(3) ? $urandom_range(20) : $urandom_range(1023),
                               $urandom_range(1), $urandom_range(1), $urandom_range(1),
                               $urandom_range(1), $urandom_range(15), $urandom_range(3));
         endcase
         directed = {33'd0, 33'd1, 33'd2200000000, 33'd4400000000, 33'd2199999999,
                     33'd4400000001, 33'h1FFFFFFFF, 33'd34375000, 33'd34374999,
                     33'd2500000000, 33'd3000000000, 33'd137500000, 33'd68750000,
                     33'd100000000, 33'd1000000000};
         if (ph > 0) directed = directed[0:6];
         foreach (directed[i]) send_target(directed[i]);
         if (ph == 0) hold_go <= 1'b1;
         for (int n = 0; n < 52; n++) send_target(random_target());
         hold_go <= 1'b0;
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
